/* src/id_length_xor_frame_receiver_assert.svh */
// Assertion macros for the frame receiver checker.
// Included by ilxfr_checker.sv; expects clk and rst in scope.
`ifndef ID_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define ID_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ILXFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILXFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ilxfr_pkg.sv */
// Shared types and constants for the length-prefixed frame receiver.
// Used by the top level and by the port checker; no dependencies.
`timescale 1ns / 1ps

package ilxfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = BYTE_W + LEN_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ID    = 2'd0,
    REG_RX_ENABLE = 2'd1
  } reg_idx_t;

endpackage

/* src/id_length_xor_frame_receiver.sv */
// Frame receiver for length-prefixed frames with an XOR checksum.
//
// Slave stream (s_axis_*) takes one received byte per word. Master stream
// (m_axis_*) gives one result word: a payload byte with its index, or the
// frame outcome (good / checksum mismatch) with the checksum byte and the
// frame length. Identifier and length bytes, dropped bytes while hunting
// and all bytes while reception is disabled give no result.
// Configuration port (cfg_*): index 0 own identifier, index 1 receive
// enable; other indexes are ignored. cfg_ready is always high.
// Path: an accepted input word passes through the input register, then
// the result register, before its result word is presented.
// Throughput: one word per cycle unless a result stalls on m_axis_tready;
// the frame state, XOR and counter update in the single stage between the two registers.
// Reset: hunting for the identifier, reception disabled, identifier zero,
// both registers empty.
// Stall: while a result waits on m_axis_tready, the input register holds
// one more word; s_axis_tready drops only when both are full.
// Depends on ilxfr_pkg.
`timescale 1ns / 1ps

module id_length_xor_frame_receiver (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ilxfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ilxfr_pkg::BYTE_W-1:0]    cfg_data,
  // received bytes
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ilxfr_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ilxfr_pkg::OUT_W-1:0]     m_axis_tdata,   // [7:0] out_byte, [23:8] out_index
  output logic [ilxfr_pkg::KIND_W-1:0]    m_axis_tuser    // [1:0] out_kind
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  logic                         own_id_en;
  logic [ilxfr_pkg::BYTE_W-1:0] own_id;
  logic                         rx_enable;

  logic                         in_valid;
  logic [ilxfr_pkg::BYTE_W-1:0] in_byte;

  phase_t                       phase, phase_next;
  logic [ilxfr_pkg::LEN_W-1:0]  frame_length, frame_length_next;
  logic [ilxfr_pkg::LEN_W-1:0]  byte_count, byte_count_next;
  logic [ilxfr_pkg::BYTE_W-1:0] running_xor, running_xor_next;

  logic                         advance;
  logic                         res_valid;
  ilxfr_pkg::kind_t             res_kind;
  logic [ilxfr_pkg::LEN_W-1:0]  res_index;

  logic                         out_valid;
  ilxfr_pkg::kind_t             out_kind;
  logic [ilxfr_pkg::BYTE_W-1:0] out_byte;
  logic [ilxfr_pkg::LEN_W-1:0]  out_index;

  assign cfg_ready     = 1'b1;
  assign own_id_en     = cfg_valid && (cfg_index == ilxfr_pkg::REG_OWN_ID);
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id    <= '0;
      rx_enable <= 1'b0;
    end else begin
      if (own_id_en) begin
        own_id <= cfg_data;
      end
      if (cfg_valid && (cfg_index == ilxfr_pkg::REG_RX_ENABLE)) begin
        rx_enable <= cfg_data[0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    res_valid         = 1'b0;
    res_kind          = ilxfr_pkg::KIND_DATA;
    res_index         = byte_count;
    if (in_valid && advance && rx_enable) begin
      case (phase)
        PH_HUNT: begin
          if (in_byte == own_id) begin
            byte_count_next   = '0;
            running_xor_next  = '0;
            frame_length_next = '0;
            phase_next        = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          frame_length_next = {in_byte, {ilxfr_pkg::BYTE_W{1'b0}}};
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = {frame_length[ilxfr_pkg::LEN_W-1:ilxfr_pkg::BYTE_W], in_byte};
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (byte_count != frame_length) begin
            running_xor_next = running_xor ^ in_byte;
            byte_count_next  = byte_count + 1'b1;
          end else begin
            // checksum byte: report and go back to hunting
            res_kind   = (in_byte == running_xor) ? ilxfr_pkg::KIND_GOOD
                                                  : ilxfr_pkg::KIND_BAD;
            res_index  = frame_length;
            phase_next = PH_HUNT;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind  <= res_kind;
      out_byte  <= in_byte;
      out_index <= res_index;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_byte};
  assign m_axis_tuser  = out_kind;

endmodule

/* src/ilxfr_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
// Depends on ilxfr_pkg and id_length_xor_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`include "id_length_xor_frame_receiver_assert.svh"

module ilxfr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ilxfr_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic [ilxfr_pkg::KIND_W-1:0]    m_axis_tuser
);

  // only the three result kinds ever leave the block
  `ILXFR_ASSERT_NOW(a_kind_legal, m_axis_tvalid, (m_axis_tuser == ilxfr_pkg::KIND_DATA) || (m_axis_tuser == ilxfr_pkg::KIND_GOOD) || (m_axis_tuser == ilxfr_pkg::KIND_BAD), "illegal result kind")

  // a stalled word holds
  `ILXFR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // output register is empty straight after reset
  `ILXFR_ASSERT_NOW(a_reset_empty, $past(rst), !m_axis_tvalid, "result present after reset")

  // a fresh result needs a prior accepted input word
  `ILXFR_ASSERT_NOW(a_latency, m_axis_tvalid && !$past(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without source word")

endmodule

bind id_length_xor_frame_receiver ilxfr_checker u_ilxfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
